>>> src/usic_pkg.sv
// usic_pkg: shared types and constants for the unique sorted index collector.
// Holds the beat structs, cell control struct, FSM state enum and defaults.
// No dependencies.
package usic_pkg;

    localparam int IDX_W           = 6;   // bucket_index / sorted_index width
    localparam int IDX_VALS        = 64;  // 2**IDX_W
    localparam int DCNT_W          = 5;   // distinct_count field width
    localparam int MAX_ENTRIES_DEF = 16;
    localparam int BUCKETS_DEF     = 64;

    typedef struct packed {
        logic [IDX_W-1:0] bucket_index;
        logic             batch_end;
    } item_t;

    typedef struct packed {
        logic [IDX_W-1:0]  sorted_index;
        logic              final_entry;
        logic [DCNT_W-1:0] distinct_count;
        logic              overflow;
    } result_t;

    typedef struct packed {
        logic insert;   // shift-insert the broadcast index
        logic drain;    // shift the row toward cell 0
    } cell_ctrl_t;

    typedef enum logic {
        ST_COLLECT,
        ST_DRAIN
    } state_t;

endpackage

>>> src/unique_sorted_index_collector.sv
// unique_sorted_index_collector: top level, deduplicating insertion sorter.
// Depends on usic_pkg and usic_cell.
//
// Usage
//   Input channel (item_valid/item_ready/item): one bucket index per beat.
//   The index is folded modulo BUCKETS, compared against every occupied slot
//   of a row of MAX_ENTRIES cells, dropped if already held, and otherwise
//   shift-inserted at its ascending place in the same cycle. While collecting,
//   item_ready is high and one beat is absorbed per cycle.
//   A distinct index arriving with the row full is dropped and sets the
//   overflow flag for the batch.
//   On the beat with batch_end set, the block switches to draining: from the
//   next cycle result_valid is high and cell 0 (the smallest index) is shown
//   on the result channel. Each accepted result beat shifts the row down one
//   cell, so N distinct indices leave as N beats, smallest first.
//   item_ready is low for the whole drain. final_entry marks the last
//   beat; distinct_count and overflow are the same on every beat of a batch.
//   A receiver stall simply holds the row and the result payload.
//   After the final beat, count and overflow clear and collection resumes
//   in the next cycle.
//   Reset (rst_n low, async) empties the row and returns to collecting; the
//   cell contents themselves are not cleared, the fill count masks them.
module unique_sorted_index_collector #(
    parameter int MAX_ENTRIES = usic_pkg::MAX_ENTRIES_DEF,
    parameter int BUCKETS     = usic_pkg::BUCKETS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  usic_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_ready,
    output usic_pkg::result_t result
);

    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int IDX_W = usic_pkg::IDX_W;

    usic_pkg::state_t     state_reg, state_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [CNT_W-1:0]     total_reg, total_next;
    logic                 ovf_reg, ovf_next;

    // Fold table: index modulo BUCKETS, worked out at elaboration.
    logic [IDX_W-1:0]     fold_lut [usic_pkg::IDX_VALS];
    logic [IDX_W-1:0]     new_idx;

    logic [IDX_W-1:0]     cell_val [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] cell_gt;
    logic [MAX_ENTRIES-1:0] cell_eq;
    logic [MAX_ENTRIES-1:0] cell_occ;

    usic_pkg::cell_ctrl_t ctrl;
    logic                 in_fire;
    logic                 out_fire;
    logic                 dup;
    logic                 full;
    logic                 last_beat;

    genvar g;
    generate
        for (g = 0; g < usic_pkg::IDX_VALS; g++)
        begin : g_fold
            assign fold_lut[g] = IDX_W'(g % BUCKETS);
        end
    endgenerate

    assign new_idx   = fold_lut[item.bucket_index];
    assign in_fire   = item_valid && item_ready;
    assign out_fire  = result_valid && result_ready;
    assign dup       = |cell_eq;
    assign full      = (cnt_reg == CNT_W'(MAX_ENTRIES));
    assign last_beat = (cnt_reg == CNT_W'(1));

    assign ctrl.insert = in_fire && !dup && !full;
    assign ctrl.drain  = out_fire;

    // Row of cells: insertion shifts up from the insert point, drain shifts down.
    generate
        for (g = 0; g < MAX_ENTRIES; g++)
        begin : g_cell
            logic [IDX_W-1:0] left_val;
            logic             left_gt;
            logic [IDX_W-1:0] right_val;

            assign cell_occ[g] = (CNT_W'(g) < cnt_reg);

            if (g == 0)
            begin : g_first
                assign left_val = new_idx;
                assign left_gt  = 1'b0;
            end
            else
            begin : g_mid
                assign left_val = cell_val[g-1];
                assign left_gt  = cell_gt[g-1];
            end

            if (g == MAX_ENTRIES - 1)
            begin : g_last
                assign right_val = cell_val[g];
            end
            else
            begin : g_inner
                assign right_val = cell_val[g+1];
            end

            usic_cell u_cell (
                .clk       (clk),
                .ctrl      (ctrl),
                .occupied  (cell_occ[g]),
                .new_idx   (new_idx),
                .left_val  (left_val),
                .left_gt   (left_gt),
                .right_val (right_val),
                .val       (cell_val[g]),
                .gt        (cell_gt[g]),
                .eq        (cell_eq[g])
            );
        end
    endgenerate

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            usic_pkg::ST_COLLECT:
            begin
                if (in_fire && item.batch_end)
                begin
                    state_next = usic_pkg::ST_DRAIN;
                end
            end
            usic_pkg::ST_DRAIN:
            begin
                if (out_fire && last_beat)
                begin
                    state_next = usic_pkg::ST_COLLECT;
                end
            end
            default:
            begin
                state_next = usic_pkg::ST_COLLECT;
            end
        endcase
    end

    // FSM outputs
    always_comb
    begin
        item_ready   = 1'b0;
        result_valid = 1'b0;
        unique case (state_reg)
            usic_pkg::ST_COLLECT: item_ready   = 1'b1;
            usic_pkg::ST_DRAIN:   result_valid = 1'b1;
            default:              item_ready   = 1'b0;
        endcase
    end

    // Count, batch total and overflow flag; input and result beats never
    // fire in the same cycle, and with neither everything holds.
    always_comb
    begin
        cnt_next   = cnt_reg;
        total_next = total_reg;
        ovf_next   = ovf_reg;
        if (in_fire)
        begin
            cnt_next = cnt_reg + CNT_W'(ctrl.insert);
            if (!dup && full)
            begin
                ovf_next = 1'b1;
            end
            if (item.batch_end)
            begin
                total_next = cnt_reg + CNT_W'(ctrl.insert);
            end
        end
        else if (out_fire)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
            if (last_beat)
            begin
                ovf_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= usic_pkg::ST_COLLECT;
            cnt_reg   <= '0;
            total_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            total_reg <= total_next;
            ovf_reg   <= ovf_next;
        end
    end

    // Result beat comes straight from cell 0 and the batch registers.
    assign result.sorted_index   = cell_val[0];
    assign result.final_entry    = last_beat;
    assign result.distinct_count = usic_pkg::DCNT_W'(total_reg);
    assign result.overflow       = ovf_reg;

endmodule

>>> src/usic_cell.sv
// usic_cell: one slot of the sorted insertion row.
// Depends on usic_pkg (cell_ctrl_t, IDX_W).
module usic_cell (
    input  logic                        clk,
    input  usic_pkg::cell_ctrl_t        ctrl,
    input  logic                        occupied,
    input  logic [usic_pkg::IDX_W-1:0]  new_idx,
    input  logic [usic_pkg::IDX_W-1:0]  left_val,
    input  logic                        left_gt,
    input  logic [usic_pkg::IDX_W-1:0]  right_val,
    output logic [usic_pkg::IDX_W-1:0]  val,
    output logic                        gt,
    output logic                        eq
);

    logic [usic_pkg::IDX_W-1:0] val_reg;
    logic [usic_pkg::IDX_W-1:0] val_next;

    // An empty slot acts as +infinity so the new index lands at the first one.
    assign gt  = !occupied || (val_reg > new_idx);
    assign eq  = occupied && (val_reg == new_idx);
    assign val = val_reg;

    // insert and drain never come together; with neither the slot holds
    always_comb
    begin
        val_next = val_reg;
        if (ctrl.insert)
        begin
            if (gt)
            begin
                val_next = left_gt ? left_val : new_idx;
            end
        end
        else if (ctrl.drain)
        begin
            val_next = right_val;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

endmodule

>>> src/usic_checker.sv
// usic_checker: port-level checks for the unique sorted index collector.
// Depends on usic_pkg; bound to unique_sorted_index_collector below.
module usic_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              item_valid,
    input logic              item_ready,
    input usic_pkg::item_t   item,
    input logic              result_valid,
    input logic              result_ready,
    input usic_pkg::result_t result
);

    // Stalled result beat holds.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result beat changed while stalled");

    // No input taken while a batch drains.
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(item_ready && result_valid))
        else $error("input ready during drain");

    // Batch end starts the drain.
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && item.batch_end |=> result_valid)
        else $error("no result after batch end");

    // Beats ascend strictly with a fixed count until the final one.
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_ready && !result.final_entry |=>
            result_valid
            && (result.sorted_index > $past(result.sorted_index))
            && (result.distinct_count == $past(result.distinct_count)))
        else $error("result order or count broken");

    // Final beat ends the batch.
    a_end: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_ready && result.final_entry |=>
            !result_valid && item_ready)
        else $error("drain did not end after final beat");

endmodule

bind unique_sorted_index_collector usic_checker u_usic_checker (.*);
